FILE: sv/sdmc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the six-component mean and covariance block.
package sdmc_pkg;

    localparam int NCOMP = 6;
    localparam int NTRI  = 21;
    localparam int COMP_W = 24;
    localparam int VAL_W  = 48;
    localparam int SUM_W  = 34;
    localparam int PSUM_W = 58;
    localparam int CNT_W  = 11;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp0;
        logic signed [COMP_W-1:0] comp1;
        logic signed [COMP_W-1:0] comp2;
        logic signed [COMP_W-1:0] comp3;
        logic signed [COMP_W-1:0] comp4;
        logic signed [COMP_W-1:0] comp5;
        logic                     final_sample;
    } sample_t;

    typedef struct packed {
        logic                    kind;
        logic [2:0]              row;
        logic [2:0]              col;
        logic signed [VAL_W-1:0] value;
        logic                    dropped;
        logic                    end_of_run;
    } result_t;

    localparam logic KIND_MEAN = 1'b0;
    localparam logic KIND_COV  = 1'b1;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MEAN,
        ST_COV_MUL,
        ST_COV_DIV,
        ST_OUT
    } back_state_t;

    // Lower-triangle row/col for t = 0..20
    function automatic logic [2:0] tri_row(input logic [4:0] t);
        logic [2:0] r;
        r = 3'd0;
        if (t >= 5'd1)  r = 3'd1;
        if (t >= 5'd3)  r = 3'd2;
        if (t >= 5'd6)  r = 3'd3;
        if (t >= 5'd10) r = 3'd4;
        if (t >= 5'd15) r = 3'd5;
        return r;
    endfunction

    function automatic logic [2:0] tri_col(input logic [4:0] t);
        logic [4:0] base;
        logic [2:0] r;
        r = tri_row(t);
        base = (5'(r) * (5'(r) + 5'd1)) >> 1;
        return 3'(t - base);
    endfunction

endpackage

FILE: sv/six_dim_mean_covariance.sv
`timescale 1ns / 1ps
// Top level: six-component sample mean and covariance accumulator.
// Throughput: one sample per cycle while accumulating; samples queue in a 4-deep FIFO.
// A final sample triggers 27 results, 6 means then 21 covariances, each from a bit-serial
// divider unless no sample was counted; samples are not taken again until the last result
// has been produced, and a result that waits on out_ready holds back the next one.
// Reset (rst_n, async active low) clears counts, sums, queue and output valid.
module six_dim_mean_covariance #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdmc_pkg::sample_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sdmc_pkg::result_t   out_data
);
    import sdmc_pkg::*;

    logic    q_valid, q_ready;
    sample_t q_data;

    sdmc_fifo #(.DEPTH_LOG2(2)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_ready (in_ready),
        .wr_data  (in_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    sdmc_back #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (q_valid),
        .s_ready (q_ready),
        .s_data  (q_data),
        .r_valid (out_valid),
        .r_ready (out_ready),
        .r_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_eor_cov: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.end_of_run |-> out_data.kind == KIND_COV
            && out_data.row == 3'd5 && out_data.col == 3'd5)
        else $error("end_of_run on wrong result");
    a_col_le_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.col <= out_data.row)
        else $error("col above row");
`endif
endmodule

FILE: sv/sdmc_fifo.sv
`timescale 1ns / 1ps
// Small sample queue between the front end and the accumulator back end.
module sdmc_fifo #(
    parameter int DEPTH_LOG2 = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  sdmc_pkg::sample_t   wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output sdmc_pkg::sample_t   rd_data
);
    import sdmc_pkg::*;

    localparam int DEPTH = 1 << DEPTH_LOG2;

    sample_t                 mem_reg [DEPTH];
    logic [DEPTH_LOG2-1:0]   wp_reg, rp_reg;
    logic [DEPTH_LOG2:0]     cnt_reg;

    assign wr_ready = (cnt_reg != (DEPTH_LOG2+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wp_reg <= wp_reg + 1'b1;
            if (rd_valid && rd_ready)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (DEPTH_LOG2+1)'(wr_valid && wr_ready)
                               - (DEPTH_LOG2+1)'(rd_valid && rd_ready);
        end
    end
endmodule

FILE: sv/sdmc_divider.sv
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle, signed truncating.
module sdmc_divider #(
    parameter int NUM_W = 80,
    parameter int DEN_W = 21,
    parameter int Q_W   = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [Q_W-1:0]   quot
);
    import sdmc_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] mag_reg, mag_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [NUM_W-1:0] qn;

    always_comb
    begin
        trial    = {rem_reg[DEN_W-1:0], mag_reg[NUM_W-1]};
        mag_next = {mag_reg[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = trial - {1'b0, den_reg};
            q_next   = {q_reg[NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial;
            q_next   = {q_reg[NUM_W-2:0], 1'b0};
        end
        qn   = neg_reg ? (~q_reg + 1'b1) : q_reg;
        quot = Q_W'(qn);
    end

    assign done = done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            neg_reg <= num[NUM_W-1];
            den_reg <= den;
            q_reg   <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_next;
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: sv/sdmc_back.sv
`timescale 1ns / 1ps
// Back end: accumulates samples and sequences the mean and covariance results.
module sdmc_back #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    input  sdmc_pkg::sample_t   s_data,
    output logic                r_valid,
    input  logic                r_ready,
    output sdmc_pkg::result_t   r_data
);
    import sdmc_pkg::*;

    localparam int NUM_W = 80;
    localparam int DEN_W = 2 * CNT_W - 1;

    back_state_t state_reg, state_next;

    logic signed [SUM_W-1:0]  csum_reg [NCOMP];
    logic signed [PSUM_W-1:0] psum_reg [NTRI];
    logic [CNT_W-1:0]         cnt_reg;
    logic                     ovf_reg;
    logic [4:0]               idx_reg, idx_next;
    logic                     out_is_cov_reg;
    result_t                  res_reg;
    logic                     res_valid_reg;

    logic signed [SAMPLE_BITS-1:0] x [NCOMP];
    logic signed [COMP_W-1:0]      raw [NCOMP];
    logic                          take;
    logic                          room;

    logic signed [NUM_W-1:0]  nsij_reg, sisj_reg;
    logic signed [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]         div_den;
    logic                     div_start;
    logic                     div_done;
    logic signed [VAL_W-1:0]  div_q;
    logic [2:0]               ri, ci;

    assign raw[0] = s_data.comp0;
    assign raw[1] = s_data.comp1;
    assign raw[2] = s_data.comp2;
    assign raw[3] = s_data.comp3;
    assign raw[4] = s_data.comp4;
    assign raw[5] = s_data.comp5;

    always_comb
    begin
        for (int k = 0; k < NCOMP; k++)
            x[k] = raw[k][SAMPLE_BITS-1:0];
    end

    assign room    = (cnt_reg < CNT_W'(MAX_SAMPLES));
    assign s_ready = (state_reg == ST_ACC);
    assign take    = s_valid && s_ready;
    assign r_valid = res_valid_reg;
    assign r_data  = res_reg;
    assign ri      = tri_row(idx_reg);
    assign ci      = tri_col(idx_reg);

    assign div_den = (state_reg == ST_MEAN) ? DEN_W'(cnt_reg)
                                            : DEN_W'(cnt_reg) * DEN_W'(cnt_reg);
    assign div_num = (state_reg == ST_MEAN)
                     ? NUM_W'(csum_reg[3'(idx_reg)])
                     : nsij_reg - sisj_reg;

    sdmc_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(VAL_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    logic div_busy_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_ACC:
            begin
                if (take && s_data.final_sample)
                begin
                    state_next = ST_MEAN;
                    idx_next   = '0;
                end
            end
            ST_MEAN:
            begin
                if (!div_busy_reg && !res_valid_reg)
                    div_start = (cnt_reg != '0);
                if (!div_busy_reg && !res_valid_reg && cnt_reg == '0)
                    state_next = ST_OUT;
                else if (div_done)
                    state_next = ST_OUT;
            end
            ST_COV_MUL:
            begin
                if (!res_valid_reg)
                    state_next = (cnt_reg == '0) ? ST_OUT : ST_COV_DIV;
            end
            ST_COV_DIV:
            begin
                if (!div_busy_reg)
                    div_start = 1'b1;
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_is_cov_reg && idx_reg == 5'd5)
                begin
                    state_next = ST_COV_MUL;
                    idx_next   = '0;
                end
                else if (out_is_cov_reg && idx_reg == 5'(NTRI - 1))
                    state_next = ST_ACC;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = out_is_cov_reg ? ST_COV_MUL : ST_MEAN;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COV_MUL)
        begin
            nsij_reg <= NUM_W'($signed({1'b0, cnt_reg})) * NUM_W'(psum_reg[idx_reg]);
            sisj_reg <= NUM_W'(csum_reg[ri]) * NUM_W'(csum_reg[ci]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_ACC;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            out_is_cov_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            div_busy_reg   <= 1'b0;
            res_reg        <= '0;
            for (int k = 0; k < NCOMP; k++)
                csum_reg[k] <= '0;
            for (int k = 0; k < NTRI; k++)
                psum_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (div_start)
                div_busy_reg <= 1'b1;
            else if (div_done)
                div_busy_reg <= 1'b0;
            if (r_valid && r_ready)
                res_valid_reg <= 1'b0;

            if (take)
            begin
                if (room)
                begin
                    for (int k = 0; k < NCOMP; k++)
                        csum_reg[k] <= csum_reg[k] + SUM_W'(x[k]);
                    for (int t = 0; t < NTRI; t++)
                        psum_reg[t] <= psum_reg[t]
                            + PSUM_W'((2*SAMPLE_BITS)'(x[tri_row(5'(t))])
                                      * (2*SAMPLE_BITS)'(x[tri_col(5'(t))]));
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else
                    ovf_reg <= 1'b1;
            end

            if (state_reg == ST_ACC && state_next == ST_MEAN)
                out_is_cov_reg <= 1'b0;

            if (state_reg == ST_OUT)
            begin
                res_valid_reg      <= 1'b1;
                res_reg.kind       <= out_is_cov_reg ? KIND_COV : KIND_MEAN;
                res_reg.row        <= out_is_cov_reg ? ri : 3'(idx_reg);
                res_reg.col        <= out_is_cov_reg ? ci : 3'(idx_reg);
                res_reg.value      <= (cnt_reg == '0) ? '0 : div_q;
                res_reg.dropped    <= ovf_reg;
                res_reg.end_of_run <= out_is_cov_reg && idx_reg == 5'(NTRI - 1);
                if (!out_is_cov_reg && idx_reg == 5'd5)
                    out_is_cov_reg <= 1'b1;
                if (out_is_cov_reg && idx_reg == 5'(NTRI - 1))
                begin
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                    for (int k = 0; k < NCOMP; k++)
                        csum_reg[k] <= '0;
                    for (int k = 0; k < NTRI; k++)
                        psum_reg[k] <= '0;
                end
            end
        end
    end
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for six_dim_mean_covariance: fixed and random sets checked by a mean/covariance predictor.
module tb;
    import sdmc_pkg::*;

    localparam int MAX_SAMPLES = 1024;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    sample_t in_data = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    result_t out_data;

    six_dim_mean_covariance dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic signed [63:0] comp_sum [NCOMP];
    logic signed [63:0] prod_sum [NTRI];
    int                 set_count;
    bit                 set_dropped;
    result_t            expected_results [$];
    int                 errors = 0;

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0;
    endfunction

    task automatic clear_set();
        for (int i = 0; i < NCOMP; i++)
            comp_sum[i] = '0;
        for (int t = 0; t < NTRI; t++)
            prod_sum[t] = '0;
        set_count = 0;
        set_dropped = 1'b0;
    endtask

    task automatic predict_sample(input sample_t s);
        logic signed [63:0]  x [NCOMP];
        logic signed [127:0] n, num, den;
        result_t             r;
        int                  t;
        x[0] = 64'(s.comp0); x[1] = 64'(s.comp1); x[2] = 64'(s.comp2);
        x[3] = 64'(s.comp3); x[4] = 64'(s.comp4); x[5] = 64'(s.comp5);
        if (set_count < MAX_SAMPLES)
        begin
            t = 0;
            for (int i = 0; i < NCOMP; i++)
            begin
                comp_sum[i] += x[i];
                for (int j = 0; j <= i; j++)
                begin
                    prod_sum[t] += x[i] * x[j];
                    t++;
                end
            end
            set_count++;
        end
        else
            set_dropped = 1'b1;
        if (!s.final_sample)
            return;
        n = 128'(set_count);
        for (int i = 0; i < NCOMP; i++)
        begin
            r.kind = KIND_MEAN;
            r.row = 3'(i);
            r.col = 3'(i);
            r.value = (n > 0) ? 48'(comp_sum[i] / 64'(set_count)) : '0;
            r.dropped = set_dropped;
            r.end_of_run = 1'b0;
            expected_results.push_back(r);
        end
        t = 0;
        for (int i = 0; i < NCOMP; i++)
            for (int j = 0; j <= i; j++)
            begin
                num = n * 128'(prod_sum[t]) - 128'(comp_sum[i]) * 128'(comp_sum[j]);
                den = n * n;
                r.kind = KIND_COV;
                r.row = 3'(i);
                r.col = 3'(j);
                r.value = (n > 0) ? 48'(num / den) : '0;
                r.dropped = set_dropped;
                r.end_of_run = (t == NTRI - 1);
                expected_results.push_back(r);
                t++;
            end
        clear_set();
    endtask

    // one transfer on the input side, entered and left at a falling edge
    task automatic send_sample(input sample_t s, input int gap);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = s;
        do @(posedge clk); while (!in_ready);
        predict_sample(s);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [23:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return 24'($signed($urandom_range(0, 512)) - 256);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic sample_t make_sample(input logic signed [23:0] v0, v1, v2, v3, v4, v5,
                                            input logic fin);
        sample_t s;
        s.comp0 = v0; s.comp1 = v1; s.comp2 = v2;
        s.comp3 = v3; s.comp4 = v4; s.comp5 = v5;
        s.final_sample = fin;
        return s;
    endfunction

    function automatic sample_t random_sample(input logic fin);
        return make_sample(rand_comp(), rand_comp(), rand_comp(),
                           rand_comp(), rand_comp(), rand_comp(), fin);
    endfunction

    task automatic test_extremes();
        localparam logic signed [23:0] HI = 24'sh7fffff;
        localparam logic signed [23:0] LO = 24'sh800000;
        send_sample(make_sample(HI, HI, HI, HI, HI, HI, 1'b1), 0);
        send_sample(make_sample(LO, LO, LO, LO, LO, LO, 1'b1), 0);
        send_sample(make_sample(HI, LO, HI, LO, HI, LO, 1'b0), 0);
        send_sample(make_sample(LO, HI, LO, HI, LO, HI, 1'b1), 0);
        send_sample(make_sample(HI, HI, HI, HI, HI, HI, 1'b0), 0);
        send_sample(make_sample(HI, HI, HI, HI, HI, HI, 1'b0), 0);
        send_sample(make_sample(LO, LO, LO, LO, LO, LO, 1'b1), 0);
        send_sample(make_sample(-24'sd1, 24'sd1, 24'sd0, -24'sd3, 24'sd2, -24'sd2, 1'b0), 0);
        send_sample(make_sample(24'sd0, -24'sd1, 24'sd1, 24'sd0, -24'sd1, 24'sd1, 1'b1), 0);
        wait_drained();
    endtask

    task automatic test_random_sets();
        int sent;
        int set_len;
        sent = 0;
        while (sent < 120)
        begin
            set_len = $urandom_range(1, 8);
            for (int k = 1; k <= set_len; k++)
                send_sample(random_sample(k == set_len), short_or_long_gap());
            sent += set_len;
            if (sent > 60 && sent <= 60 + set_len)
                wait_drained();
        end
        in_valid = 1'b0;
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0)
                out_ready = 1'b1;
            else
            begin
                out_ready = 1'b0;
                repeat (short_or_long_gap()) @(negedge clk);
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual %p", $realtime, out_data);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.kind !== want.kind || out_data.row !== want.row ||
                    out_data.col !== want.col || out_data.value !== want.value ||
                    out_data.dropped !== want.dropped ||
                    out_data.end_of_run !== want.end_of_run)
                begin
                    $display("%0t: mismatch, expected %p, actual %p",
                             $realtime, want, out_data);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        clear_set();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_extremes();
        test_random_sets();
        wait_drained();
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: filelist.f
sv/sdmc_pkg.sv
sv/sdmc_fifo.sv
sv/sdmc_divider.sv
sv/sdmc_back.sv
sv/six_dim_mean_covariance.sv
verif/tb.sv
